// ----- src/tfla_pkg.sv -----
// Package for the connection slot table: sizes, state and status codes,
// shared command/status structs. No dependencies.
`timescale 1ns / 1ps
package tfla_pkg;
    localparam int SLOTS = 64;
    localparam int IDX_W = 6;

    localparam logic [1:0] FN_LOOKUP = 2'd0;
    localparam logic [1:0] FN_ALLOC  = 2'd1;
    localparam logic [1:0] FN_WRITE  = 2'd2;
    localparam logic [1:0] FN_COUNT  = 2'd3;

    localparam logic [2:0] SS_FREE     = 3'd0;
    localparam logic [2:0] SS_SYN_RECV = 3'd1;
    localparam logic [2:0] SS_ESTAB    = 3'd2;
    localparam logic [2:0] SS_TWAIT    = 3'd3;

    localparam logic [1:0] RS_OK       = 2'd0;
    localparam logic [1:0] RS_NOT_FOUND = 2'd1;
    localparam logic [1:0] RS_LIMIT    = 2'd2;
    localparam logic [1:0] RS_NO_SLOT  = 2'd3;

    typedef enum logic [1:0] {
        SC_MATCH,
        SC_EVICT,
        SC_COUNT
    } scan_kind_t;

    typedef struct packed {
        logic       load;
        logic       scan_first;
        logic       scan_step;
        scan_kind_t kind;
        logic       do_write;
        logic       do_evict;
        logic       do_alloc;
    } dp_cmd_t;

    typedef struct packed {
        logic             scan_last;
        logic             any_free;
        logic [IDX_W-1:0] free_idx;
        logic             found;
        logic [IDX_W-1:0] found_idx;
        logic             have_cand;
        logic [IDX_W-1:0] cand_idx;
    } dp_stat_t;
endpackage

// ----- src/tfla_datapath.sv -----
// Slot store and per-slot scan unit for the connection table.
// Depends on tfla_pkg.
`timescale 1ns / 1ps
module tfla_datapath
    import tfla_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic              is_v6,
    input  logic [15:0]       lport,
    input  logic [15:0]       rport,
    input  logic [63:0]       addr_hi,
    input  logic [63:0]       addr_lo,
    input  logic [IDX_W-1:0]  slot_select,
    input  logic [2:0]        new_state,
    input  logic [63:0]       seen_time,
    output dp_stat_t          stat,
    output logic [6:0]        est_count
);
    logic [2:0]  st_reg [SLOTS];
    logic [15:0] lp_mem [SLOTS];
    logic [15:0] rp_mem [SLOTS];
    logic [31:0] v4_mem [SLOTS];
    logic [63:0] hi_mem [SLOTS];
    logic [63:0] lo_mem [SLOTS];
    logic [63:0] ts_mem [SLOTS];

    logic        v6_reg;
    logic [15:0] lp_reg, rp_reg;
    logic [63:0] hi_reg, lo_reg;

    logic [IDX_W-1:0] ptr_reg;
    logic             run_reg, rv_reg, fin_reg;
    logic [IDX_W-1:0] ri_reg;
    logic             found_reg, have_reg, free_reg;
    logic [IDX_W-1:0] found_idx_reg, cand_idx_reg, free_idx_reg;
    logic [63:0]      cand_ts_reg;
    logic [6:0]       cnt_reg;

    logic [2:0]  rd_st_reg;
    logic [15:0] rd_lp_reg, rd_rp_reg;
    logic [31:0] rd_v4_reg;
    logic [63:0] rd_hi_reg, rd_lo_reg, rd_ts_reg;
    logic        match;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v6_reg <= is_v6;
            lp_reg <= lport;
            rp_reg <= rport;
            hi_reg <= addr_hi;
            lo_reg <= addr_lo;
        end
        if (cmd.do_write)
        begin
            lp_mem[slot_select] <= lport;
            rp_mem[slot_select] <= rport;
            ts_mem[slot_select] <= seen_time;
            if (is_v6)
            begin
                hi_mem[slot_select] <= addr_hi;
                lo_mem[slot_select] <= addr_lo;
            end
            else
                v4_mem[slot_select] <= addr_lo[31:0];
        end
        else if (cmd.do_alloc)
        begin
            v4_mem[free_idx_reg] <= '0;
            hi_mem[free_idx_reg] <= '0;
            lo_mem[free_idx_reg] <= '0;
        end
        // Registered reads for the slot under the scan pointer; evaluated next cycle.
        rd_st_reg <= st_reg[ptr_reg];
        rd_lp_reg <= lp_mem[ptr_reg];
        rd_rp_reg <= rp_mem[ptr_reg];
        rd_v4_reg <= v4_mem[ptr_reg];
        rd_hi_reg <= hi_mem[ptr_reg];
        rd_lo_reg <= lo_mem[ptr_reg];
        rd_ts_reg <= ts_mem[ptr_reg];
    end

    always_comb
    begin
        match = (rd_lp_reg == lp_reg) && (rd_rp_reg == rp_reg);
        if (v6_reg)
            match = match && (rd_hi_reg == hi_reg) && (rd_lo_reg == lo_reg);
        else
            match = match && (rd_v4_reg == lo_reg[31:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                st_reg[i] <= SS_FREE;
            ptr_reg   <= '0;
            run_reg   <= 1'b0;
            rv_reg    <= 1'b0;
            fin_reg   <= 1'b0;
            ri_reg    <= '0;
            found_reg <= 1'b0;
            have_reg  <= 1'b0;
            free_reg  <= 1'b0;
            cnt_reg   <= '0;
            found_idx_reg <= '0;
            cand_idx_reg  <= '0;
            free_idx_reg  <= '0;
            cand_ts_reg   <= '0;
        end
        else
        begin
            if (cmd.do_write)
                st_reg[slot_select] <= new_state;
            else if (cmd.do_evict)
                st_reg[cand_idx_reg] <= SS_FREE;
            else if (cmd.do_alloc)
                st_reg[free_idx_reg] <= SS_SYN_RECV;

            if (cmd.scan_first)
            begin
                ptr_reg   <= '0;
                run_reg   <= 1'b1;
                rv_reg    <= 1'b0;
                fin_reg   <= 1'b0;
                found_reg <= 1'b0;
                have_reg  <= 1'b0;
                free_reg  <= 1'b0;
                cnt_reg   <= '0;
            end
            else
            begin
                // Pulse once the last slot has been evaluated.
                fin_reg <= rv_reg && (ri_reg == IDX_W'(SLOTS - 1));
                rv_reg  <= cmd.scan_step && run_reg;
                ri_reg  <= ptr_reg;
                if (cmd.scan_step && run_reg)
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == IDX_W'(SLOTS - 1))
                        run_reg <= 1'b0;
                end
                if (rv_reg)
                begin
                    case (cmd.kind)
                        SC_MATCH:
                        begin
                            if (!found_reg && rd_st_reg != SS_FREE && match)
                            begin
                                found_reg     <= 1'b1;
                                found_idx_reg <= ri_reg;
                            end
                            if (!free_reg && rd_st_reg == SS_FREE)
                            begin
                                free_reg     <= 1'b1;
                                free_idx_reg <= ri_reg;
                            end
                        end
                        SC_EVICT:
                        begin
                            // After eviction only the freed slot can be free.
                            if (rd_st_reg == SS_TWAIT && !match &&
                                (!have_reg || rd_ts_reg < cand_ts_reg))
                            begin
                                have_reg     <= 1'b1;
                                cand_idx_reg <= ri_reg;
                                cand_ts_reg  <= rd_ts_reg;
                            end
                        end
                        SC_COUNT:
                        begin
                            if (rd_st_reg == SS_ESTAB)
                                cnt_reg <= cnt_reg + 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (cmd.do_evict)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= cand_idx_reg;
                end
            end
        end
    end

    assign stat.scan_last = fin_reg;
    assign stat.any_free  = free_reg;
    assign stat.free_idx  = free_idx_reg;
    assign stat.found     = found_reg;
    assign stat.found_idx = found_idx_reg;
    assign stat.have_cand = have_reg;
    assign stat.cand_idx  = cand_idx_reg;
    assign est_count      = cnt_reg;
endmodule

// ----- src/tfla_ctrl.sv -----
// Operation sequencer for the connection table: scans, commits, result strobe.
// Depends on tfla_pkg.
`timescale 1ns / 1ps
module tfla_ctrl
    import tfla_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       func,
    input  logic [10:0]      half_open_now,
    input  logic [10:0]      limit,
    input  dp_stat_t         stat,
    input  logic [6:0]       est_count,
    output dp_cmd_t          cmd,
    output logic             busy,
    output logic             done,
    output logic [1:0]       status,
    output logic [IDX_W-1:0] slot_index,
    output logic             recycled,
    output logic [IDX_W-1:0] recycled_index,
    output logic [6:0]       active_count
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVSCAN,
        S_EVICT,
        S_ALLOC,
        S_CNT
    } state_t;

    state_t           state_reg;
    logic [1:0]       func_reg;
    logic             done_reg, rec_reg;
    logic [1:0]       status_reg;
    logic [IDX_W-1:0] idx_reg, rec_idx_reg;
    logic [6:0]       cnt_reg;

    always_comb
    begin
        cmd = '0;
        cmd.kind = SC_MATCH;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                cmd.scan_first = start;
                cmd.do_write = start && func == FN_WRITE;
            end
            S_SCAN:   cmd.scan_step = 1'b1;
            S_EVSCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.kind = SC_EVICT;
            end
            S_EVICT:  cmd.do_evict = stat.have_cand;
            S_ALLOC:
            begin
                cmd.do_alloc = stat.any_free;
                cmd.scan_first = !stat.any_free && !rec_reg;
            end
            S_CNT:
            begin
                cmd.scan_step = 1'b1;
                cmd.kind = SC_COUNT;
            end
            default:
            begin
            end
        endcase
    end

    assign busy = state_reg != S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            func_reg    <= FN_LOOKUP;
            done_reg    <= 1'b0;
            status_reg  <= RS_OK;
            idx_reg     <= '0;
            rec_reg     <= 1'b0;
            rec_idx_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        func_reg    <= func;
                        rec_reg     <= 1'b0;
                        rec_idx_reg <= '0;
                        cnt_reg     <= '0;
                        idx_reg     <= '0;
                        case (func)
                            FN_WRITE:
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= RS_OK;
                            end
                            FN_COUNT: state_reg <= S_CNT;
                            FN_ALLOC:
                                if (half_open_now >= limit)
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= RS_LIMIT;
                                end
                                else
                                    state_reg <= S_SCAN;
                            default:  state_reg <= S_SCAN;
                        endcase
                    end
                S_SCAN:
                    if (stat.scan_last)
                    begin
                        if (func_reg == FN_LOOKUP)
                        begin
                            state_reg <= S_IDLE;
                            done_reg  <= 1'b1;
                        end
                        else
                            state_reg <= S_ALLOC;
                    end
                S_ALLOC:
                    if (!stat.any_free && !rec_reg)
                        state_reg <= S_EVSCAN;
                    else
                    begin
                        state_reg  <= S_IDLE;
                        done_reg   <= 1'b1;
                        status_reg <= stat.any_free ? RS_OK : RS_NO_SLOT;
                        idx_reg    <= stat.any_free ? stat.free_idx : '0;
                    end
                S_EVSCAN:
                    if (stat.scan_last)
                        state_reg <= S_EVICT;
                S_EVICT:
                begin
                    rec_reg     <= 1'b1;
                    rec_idx_reg <= stat.cand_idx;
                    if (!stat.have_cand)
                    begin
                        rec_reg     <= 1'b0;
                        rec_idx_reg <= '0;
                        state_reg   <= S_IDLE;
                        done_reg    <= 1'b1;
                        status_reg  <= RS_NO_SLOT;
                    end
                    else
                        state_reg <= S_ALLOC;
                end
                S_CNT:
                    if (stat.scan_last)
                    begin
                        state_reg  <= S_IDLE;
                        done_reg   <= 1'b1;
                        status_reg <= RS_OK;
                    end
                default: state_reg <= S_IDLE;
            endcase
            // Lookup result captured once the scan has evaluated every slot.
            if (state_reg == S_SCAN && stat.scan_last && func_reg == FN_LOOKUP)
            begin
                status_reg <= stat.found ? RS_OK : RS_NOT_FOUND;
                idx_reg    <= stat.found ? stat.found_idx : '0;
            end
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign slot_index     = idx_reg;
    assign recycled       = rec_reg;
    assign recycled_index = rec_idx_reg;
    assign active_count   = (state_reg == S_IDLE && done_reg && func_reg == FN_COUNT)
                            ? est_count : cnt_reg;
endmodule

// ----- src/tcp_flow_table_lookup_alloc.sv -----
// Connection slot table: lookup, guarded allocate with oldest TWAIT
// eviction, slot write and established count. Lookup and count run one
// scan; allocate adds an allocate step and, when full, an eviction scan and
// evict step, then allocates again if it evicted. Write and a refused
// allocate finish straight from idle. A scan reads one slot per cycle through
// registered reads. One transaction at a time; busy is high while one runs,
// and a new one may start in the result cycle. rst_n (async, low) frees every
// slot and sets the limit to 32; result is shown for one cycle on done, no stall.
`timescale 1ns / 1ps
module tcp_flow_table_lookup_alloc
    import tfla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic [1:0]  func,
    input  logic        is_v6,
    input  logic [15:0] lport,
    input  logic [15:0] rport,
    input  logic [63:0] addr_hi,
    input  logic [63:0] addr_lo,
    input  logic [10:0] half_open_now,
    input  logic [5:0]  slot_select,
    input  logic [2:0]  new_state,
    input  logic [63:0] seen_time,
    output logic [1:0]  status,
    output logic [5:0]  slot_index,
    output logic        recycled,
    output logic [5:0]  recycled_index,
    output logic [6:0]  active_count
);
    logic [10:0] max_half_open_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [6:0]  est_count;
    logic [5:0]  wr_idx_reg;
    logic        wr_done_reg;
    logic [5:0]  ctl_idx;

    // Hold the half-open limit; the user must write it only while idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_half_open_reg <= 11'd32;
        else if (cfg_we)
            max_half_open_reg <= cfg_wdata;
    end

    // Write echoes its slot; capture it here beside the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg  <= '0;
            wr_done_reg <= 1'b0;
        end
        else
        begin
            wr_done_reg <= cmd.do_write;
            if (cmd.do_write)
                wr_idx_reg <= slot_select;
        end
    end

    tfla_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .is_v6       (is_v6),
        .lport       (lport),
        .rport       (rport),
        .addr_hi     (addr_hi),
        .addr_lo     (addr_lo),
        .slot_select (slot_select),
        .new_state   (new_state),
        .seen_time   (seen_time),
        .stat        (stat),
        .est_count   (est_count)
    );

    tfla_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .func           (func),
        .half_open_now  (half_open_now),
        .limit          (max_half_open_reg),
        .stat           (stat),
        .est_count      (est_count),
        .cmd            (cmd),
        .busy           (busy),
        .done           (done),
        .status         (status),
        .slot_index     (ctl_idx),
        .recycled       (recycled),
        .recycled_index (recycled_index),
        .active_count   (active_count)
    );

    assign slot_index = wr_done_reg ? wr_idx_reg : ctl_idx;

`ifndef SYNTH
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");
    a_rec_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && recycled |-> status == RS_OK)
        else $error("recycle without allocation");
    a_start_lone: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !(done && $past(func) != FN_WRITE && !busy && $past(func) != FN_ALLOC))
        else $error("early result");
`endif
endmodule
